// ----- sv/clique_associative_memory_defines.svh -----
// Assertion macros used by the clique associative memory top level.
`ifndef CLIQUE_ASSOCIATIVE_MEMORY_DEFINES_SVH
`define CLIQUE_ASSOCIATIVE_MEMORY_DEFINES_SVH
// Property checked on every rising clock edge outside reset.
`define CAM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Property checked on every edge, reset included.
`define CAM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);
`endif

// ----- sv/cam_pkg.sv -----
// Package for the clique associative memory: types, constants, codes.
`timescale 1ns / 1ps
package cam_pkg;
   localparam int CAM_CLUSTERS   = 8;
   localparam int CAM_NEURONS    = 16;
   localparam int CAM_COUNT_BITS = 8;
   localparam int FIELD_BITS     = 4;
   localparam int SLOTS          = 8;

   typedef enum logic [2:0] {
      FUNC_STORE     = 3'd0,
      FUNC_ACTIVATE  = 3'd1,
      FUNC_PROPAGATE = 3'd2,
      FUNC_STABILIZE = 3'd3,
      FUNC_STIMULATE = 3'd4,
      FUNC_SHUTDOWN  = 3'd5,
      FUNC_CLEAR     = 3'd6,
      FUNC_NONE      = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LINK,
      ST_PROP,
      ST_STAB,
      ST_CNTCLR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0] func;
      logic [3:0] neuron_0;
      logic [3:0] neuron_1;
      logic [3:0] neuron_2;
      logic [3:0] neuron_3;
      logic [3:0] neuron_4;
      logic [3:0] neuron_5;
      logic [3:0] neuron_6;
      logic [3:0] neuron_7;
      logic [2:0] stim_cluster;
      logic [3:0] stim_neuron;
   } req_type;

   typedef struct packed {
      logic [3:0] active_0;
      logic [3:0] active_1;
      logic [3:0] active_2;
      logic [3:0] active_3;
      logic [3:0] active_4;
      logic [3:0] active_5;
      logic [3:0] active_6;
      logic [3:0] active_7;
      logic       active_valid;
   } rsp_type;

   // Counter memory commands from the sequencer.
   typedef struct packed {
      logic rd;
      logic inc;
      logic clr;
   } cnt_ctl_type;
endpackage

// ----- sv/cam_link_mem.sv -----
// Link store: one row of link bits per neuron, registered read.
`timescale 1ns / 1ps
module cam_link_mem import cam_pkg::*; #(
   parameter int TOTAL = CAM_CLUSTERS * CAM_NEURONS
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(TOTAL)-1:0] waddr,
   input  logic [TOTAL-1:0]         wdata,
   input  logic [$clog2(TOTAL)-1:0] raddr,
   output logic [TOTAL-1:0]         rdata
);
   logic [TOTAL-1:0] mem [TOTAL];

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end
endmodule

// ----- sv/cam_count_mem.sv -----
// Stimulation count store: read-modify-write with saturation, one entry a cycle.
`timescale 1ns / 1ps
module cam_count_mem import cam_pkg::*; #(
   parameter int TOTAL      = CAM_CLUSTERS * CAM_NEURONS,
   parameter int COUNT_BITS = CAM_COUNT_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cnt_ctl_type              ctl,
   input  logic [$clog2(TOTAL)-1:0] addr,
   output logic [COUNT_BITS-1:0]    rdata
);
   localparam int AW = $clog2(TOTAL);
   logic [COUNT_BITS-1:0] mem [TOTAL];
   logic [AW-1:0]         wa_ff;
   logic                  winc_ff;
   logic                  fwd_ff;
   logic [COUNT_BITS-1:0] wval_ff;
   logic [COUNT_BITS-1:0] wval;
   logic [COUNT_BITS-1:0] rd_raw;
   logic [COUNT_BITS-1:0] fwd_in;
   logic                  rd_en;

   assign rd_en = ctl.rd || ctl.inc;

   // Pending increment from the prior cycle; forward it when the same entry
   // was read in the cycle it was written
   always_ff @(posedge clock) begin
      if (reset) begin
         winc_ff <= 1'b0;
         fwd_ff  <= 1'b0;
      end else begin
         winc_ff <= ctl.inc;
         fwd_ff  <= winc_ff && rd_en && (wa_ff == addr);
      end
      wa_ff   <= addr;
      wval_ff <= wval;
   end

   assign fwd_in = fwd_ff ? wval_ff : rd_raw;
   assign wval   = (&fwd_in) ? fwd_in : fwd_in + 1'b1;

   // Write stage: clear writes zero, else the saturated increment lands
   always_ff @(posedge clock) begin
      if (ctl.clr) begin
         mem[addr] <= '0;
      end else if (winc_ff) begin
         mem[wa_ff] <= wval;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_raw <= mem[addr];
      end
   end

   assign rdata = fwd_in;
endmodule

// ----- sv/clique_associative_memory.sv -----
// Top level: clique associative memory with its sequencer.
// Per item: activate, stimulate and the spare code go straight to the strobe; store updates k rows;
//   clear wipes the link store, shutdown the count store; stabilize scans, then clears the counts;
//   propagate walks TOTAL bits per activated cluster when a clique is active.
// Throughput: one item at a time; busy is high until the strobe cycle, which takes
//   the next item. The receiver cannot stall; the result strobe lasts one cycle.
// Reset: synchronous, active high; count then link store cleared, busy until both are done.
`timescale 1ns / 1ps
module clique_associative_memory import cam_pkg::*; #(
   parameter int CLUSTERS   = CAM_CLUSTERS,
   parameter int NEURONS    = CAM_NEURONS,
   parameter int COUNT_BITS = CAM_COUNT_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item,
   input  logic    csr_we,
   input  logic [3:0] csr_wdata
);
`include "clique_associative_memory_defines.svh"
   localparam int TOTAL = CLUSTERS * NEURONS;
   localparam int AW    = $clog2(TOTAL);
   localparam int NW    = $clog2(NEURONS);
   localparam int CW    = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
   localparam int KW    = $clog2(CLUSTERS + 1);

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [KW-1:0] k_ff;
   logic [KW-1:0] alen_ff, alen_in;
   logic          apres_ff, apres_in;
   logic [3:0]    act_ff [SLOTS];
   logic [3:0]    act_in [SLOTS];
   logic [AW:0]   cnt_ff, cnt_in;
   logic [KW:0]   row_ff, row_in;
   logic          pass_ff, pass_in;
   logic          init_ff, init_in;
   logic [COUNT_BITS-1:0] best_ff [SLOTS];
   logic [COUNT_BITS-1:0] best_in [SLOTS];
   logic [3:0]    win_ff [SLOTS];
   logic [3:0]    win_in [SLOTS];
   logic [AW-1:0] rdq_ff;
   logic          rdv_ff;

   logic [3:0] nsel [SLOTS];
   logic          lwe;
   logic [AW-1:0] lwa, lra, caddr;
   logic [TOTAL-1:0] lwd, lrd;
   cnt_ctl_type   cctl;
   logic [COUNT_BITS-1:0] crd;
   logic          accept;

   assign nsel[0] = req_ff.neuron_0;  assign nsel[1] = req_ff.neuron_1;
   assign nsel[2] = req_ff.neuron_2;  assign nsel[3] = req_ff.neuron_3;
   assign nsel[4] = req_ff.neuron_4;  assign nsel[5] = req_ff.neuron_5;
   assign nsel[6] = req_ff.neuron_6;  assign nsel[7] = req_ff.neuron_7;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   cam_link_mem #(.TOTAL(TOTAL)) u_link (
      .clock(clock), .we(lwe), .waddr(lwa), .wdata(lwd), .raddr(lra), .rdata(lrd));
   cam_count_mem #(.TOTAL(TOTAL), .COUNT_BITS(COUNT_BITS)) u_cnt (
      .clock(clock), .reset(reset), .ctl(cctl), .addr(caddr), .rdata(crd));

   // Row of a store item, the same for every cluster of the clique: bits of the first k chosen neurons
   function automatic logic [TOTAL-1:0] clique_row(input logic [3:0] ns [SLOTS],
                                                   input logic [KW-1:0] k);
      logic [TOTAL-1:0] r;
      r = '0;
      for (int j = 0; j < CLUSTERS; j++) begin
         if (j < int'(k) && int'(ns[j]) < NEURONS) begin
            r[j*NEURONS + int'(ns[j])] = 1'b1;
         end
      end
      return r;
   endfunction

   // Config register, clamped
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= KW'(CLUSTERS);
      end else if (csr_we) begin
         if (csr_wdata == 4'd0) k_ff <= KW'(1);
         else if (int'(csr_wdata) > CLUSTERS) k_ff <= KW'(CLUSTERS);
         else k_ff <= KW'(csr_wdata);
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CNTCLR;
         alen_ff  <= '0;
         apres_ff <= 1'b0;
         cnt_ff   <= '0;
         row_ff   <= '0;
         pass_ff  <= 1'b0;
         init_ff  <= 1'b1;
         rdv_ff   <= 1'b0;
         for (int i = 0; i < SLOTS; i++) act_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         alen_ff  <= alen_in;
         apres_ff <= apres_in;
         cnt_ff   <= cnt_in;
         row_ff   <= row_in;
         pass_ff  <= pass_in;
         init_ff  <= init_in;
         rdv_ff   <= (state_ff == ST_PROP || state_ff == ST_STAB) && cnt_ff < (AW+1)'(TOTAL);
         for (int i = 0; i < SLOTS; i++) act_ff[i] <= act_in[i];
      end
      if (accept) req_ff <= req_item;
      rdq_ff <= cnt_ff[AW-1:0];
      for (int i = 0; i < SLOTS; i++) begin
         best_ff[i] <= best_in[i];
         win_ff[i]  <= win_in[i];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (func_type'(req_item.func))
                  FUNC_STORE:     state_in = ST_LINK;
                  FUNC_CLEAR:     state_in = ST_LINK;
                  FUNC_PROPAGATE: state_in = ST_PROP;
                  FUNC_STABILIZE: state_in = ST_STAB;
                  FUNC_SHUTDOWN:  state_in = ST_CNTCLR;
                  default:        state_in = ST_DONE;
               endcase
            end
         end
         ST_LINK: begin
            if (func_type'(req_ff.func) == FUNC_STORE && !init_ff) begin
               if (row_ff >= (KW+1)'(k_ff)) state_in = ST_DONE;
            end else if (cnt_ff >= (AW+1)'(TOTAL-1)) begin
               state_in = init_ff ? ST_IDLE : ST_DONE;
            end
         end
         ST_PROP: begin
            if (!apres_ff || row_ff >= (KW+1)'(alen_ff)) state_in = ST_DONE;
         end
         ST_STAB: begin
            if (cnt_ff == (AW+1)'(TOTAL) && !rdv_ff) state_in = ST_CNTCLR;
         end
         ST_CNTCLR: begin
            if (cnt_ff >= (AW+1)'(TOTAL-1)) state_in = init_ff ? ST_LINK : ST_DONE;
         end
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      logic [AW-1:0] src;
      logic [NW-1:0] nn;
      logic [CW-1:0] cc;
      logic [CW-1:0] pc;
      src = '0; nn = '0; cc = '0; pc = '0;
      alen_in  = alen_ff;
      apres_in = apres_ff;
      cnt_in   = cnt_ff;
      row_in   = row_ff;
      pass_in  = pass_ff;
      init_in  = init_ff;
      lwe = 1'b0; lwa = '0; lwd = '0; lra = '0;
      cctl = '0; caddr = cnt_ff[AW-1:0];
      for (int i = 0; i < SLOTS; i++) begin
         act_in[i]  = act_ff[i];
         best_in[i] = best_ff[i];
         win_in[i]  = win_ff[i];
      end
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0; row_in = '0; pass_in = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
               best_in[i] = '0; win_in[i] = '0;
            end
         end
         ST_LINK: begin
            if (func_type'(req_ff.func) == FUNC_STORE && !init_ff) begin
               // Row for cluster row_ff gets OR of clique bits; read-modify-write
               if (row_ff < (KW+1)'(k_ff)) begin
                  lra = AW'(row_ff) * AW'(NEURONS) + AW'(nsel[row_ff[CW-1:0]]);
               end
               // Write back the row read in the previous cycle
               if (pass_ff) begin
                  pc  = row_ff[CW-1:0] - CW'(1);
                  lwe = int'(nsel[pc]) < NEURONS;
                  lwa = AW'(pc) * AW'(NEURONS) + AW'(nsel[pc]);
                  lwd = lrd | clique_row(nsel, k_ff);
               end
               pass_in = row_ff < (KW+1)'(k_ff);
               row_in  = row_ff + 1'b1;
            end else begin
               lwe = 1'b1; lwa = cnt_ff[AW-1:0]; lwd = '0;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff >= (AW+1)'(TOTAL-1)) init_in = 1'b0;
            end
         end
         ST_PROP: begin
            // Per active row: first read the row, then walk TOTAL bits
            if (apres_ff && row_ff < (KW+1)'(alen_ff)) begin
               cc  = row_ff[CW-1:0];
               src = AW'(cc) * AW'(NEURONS) + AW'(act_ff[cc]);
               lra = src;
               if (!pass_ff) begin
                  pass_in = 1'b1;
                  cnt_in  = '0;
               end else begin
                  caddr    = cnt_ff[AW-1:0];
                  cctl.inc = lrd[cnt_ff[AW-1:0]] && int'(act_ff[cc]) < NEURONS;
                  cnt_in   = cnt_ff + 1'b1;
                  if (cnt_ff == (AW+1)'(TOTAL-1)) begin
                     pass_in = 1'b0;
                     row_in  = row_ff + 1'b1;
                  end
               end
            end
         end
         ST_STAB: begin
            // Scan counters; winner update in the cycle after the read
            if (cnt_ff < (AW+1)'(TOTAL)) begin
               cctl.rd = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end
            if (rdv_ff) begin
               // Split the entry number into cluster and neuron by compares
               for (int c = 1; c < CLUSTERS; c++) begin
                  if (rdq_ff >= AW'(c * NEURONS)) cc = CW'(c);
               end
               nn = NW'(rdq_ff - AW'(int'(cc) * NEURONS));
               if (crd != '0 && crd >= best_ff[cc]) begin
                  best_in[cc] = crd;
                  win_in[cc]  = 4'(nn);
               end
            end
            if (state_in == ST_CNTCLR) begin
               cnt_in = '0;
               for (int i = 0; i < SLOTS; i++) begin
                  act_in[i] = (i < int'(k_ff) && i < CLUSTERS) ? win_ff[i] : 4'd0;
               end
               alen_in  = k_ff;
               apres_in = 1'b1;
            end
         end
         ST_CNTCLR: begin
            cctl.clr = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (state_in != ST_CNTCLR) cnt_in = '0;
            if (!init_ff && func_type'(req_ff.func) == FUNC_SHUTDOWN) begin
               alen_in  = '0;
               apres_in = 1'b0;
               for (int i = 0; i < SLOTS; i++) act_in[i] = '0;
            end
         end
         ST_DONE: begin
            if (func_type'(req_ff.func) == FUNC_ACTIVATE) begin
               for (int i = 0; i < SLOTS; i++) begin
                  act_in[i] = (i < int'(k_ff)) ? nsel[i] : 4'd0;
               end
               alen_in  = k_ff;
               apres_in = 1'b1;
            end
            if (func_type'(req_ff.func) == FUNC_STIMULATE &&
                int'(req_ff.stim_cluster) < CLUSTERS && int'(req_ff.stim_neuron) < NEURONS) begin
               cctl.inc = 1'b1;
               caddr = AW'(req_ff.stim_cluster) * AW'(NEURONS) + AW'(req_ff.stim_neuron);
            end
         end
         default: ;
      endcase
   end

   // Result: one strobe as the item retires
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= (state_ff == ST_DONE);
      end
   end

   always_comb begin
      rsp_item.active_0 = act_ff[0]; rsp_item.active_1 = act_ff[1];
      rsp_item.active_2 = act_ff[2]; rsp_item.active_3 = act_ff[3];
      rsp_item.active_4 = act_ff[4]; rsp_item.active_5 = act_ff[5];
      rsp_item.active_6 = act_ff[6]; rsp_item.active_7 = act_ff[7];
      rsp_item.active_valid = apres_ff;
   end

   `CAM_ASSERT(a_strobe_idle, rsp_strobe |-> !busy, "result while busy")
   `CAM_ASSERT(a_accept_busy, accept |=> busy, "accepted item not busy")
   `CAM_ASSERT(a_strobe_pulse, rsp_strobe |=> !rsp_strobe, "strobe held")
   `CAM_ASSERT_ALWAYS(a_reset_busy, reset |=> busy, "busy low after reset")
endmodule
